[design/mixed_script_text_inspector_core_defines.svh]
// Assertion macros used by the inspector RTL.
`ifndef MIXED_SCRIPT_TEXT_INSPECTOR_CORE_DEFINES_SVH
`define MIXED_SCRIPT_TEXT_INSPECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MSTXI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MSTXI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mstxi_pkg.sv]
`timescale 1ns / 1ps

package mstxi_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned SCRIPT_W = 3;

    // script set bits
    localparam logic [SCRIPT_W-1:0] SCRIPT_LATIN    = 3'b001;
    localparam logic [SCRIPT_W-1:0] SCRIPT_CYRILLIC = 3'b010;
    localparam logic [SCRIPT_W-1:0] SCRIPT_GREEK    = 3'b100;
    localparam logic [SCRIPT_W-1:0] SCRIPT_NONE     = 3'b000;

    // bidi controls
    localparam logic [CP_W-1:0] BIDI_EMB_LO = 21'h0202A;
    localparam logic [CP_W-1:0] BIDI_EMB_HI = 21'h0202E;
    localparam logic [CP_W-1:0] BIDI_ISO_LO = 21'h02066;
    localparam logic [CP_W-1:0] BIDI_ISO_HI = 21'h02069;

    // zero-width characters
    localparam logic [CP_W-1:0] ZW_LO    = 21'h0200B;
    localparam logic [CP_W-1:0] ZW_HI    = 21'h0200D;
    localparam logic [CP_W-1:0] ZW_WJ    = 21'h02060;
    localparam logic [CP_W-1:0] ZW_BOM   = 21'h0FEFF;

    // letters
    localparam logic [CP_W-1:0] LAT_UP_LO = 21'h00041;
    localparam logic [CP_W-1:0] LAT_UP_HI = 21'h0005A;
    localparam logic [CP_W-1:0] LAT_LO_LO = 21'h00061;
    localparam logic [CP_W-1:0] LAT_LO_HI = 21'h0007A;
    localparam logic [CP_W-1:0] CYR_LO    = 21'h00400;
    localparam logic [CP_W-1:0] CYR_HI    = 21'h0052F;
    localparam logic [CP_W-1:0] GRK_LO    = 21'h00370;
    localparam logic [CP_W-1:0] GRK_HI    = 21'h003FF;

    // whitespace
    localparam logic [CP_W-1:0] WS_CTL_LO = 21'h00009;
    localparam logic [CP_W-1:0] WS_CTL_HI = 21'h0000D;
    localparam logic [CP_W-1:0] WS_SPACE  = 21'h00020;
    localparam logic [CP_W-1:0] WS_NEL    = 21'h00085;
    localparam logic [CP_W-1:0] WS_NBSP   = 21'h000A0;
    localparam logic [CP_W-1:0] WS_OGHAM  = 21'h01680;
    localparam logic [CP_W-1:0] WS_EN_LO  = 21'h02000;
    localparam logic [CP_W-1:0] WS_EN_HI  = 21'h0200A;
    localparam logic [CP_W-1:0] WS_LSEP   = 21'h02028;
    localparam logic [CP_W-1:0] WS_PSEP   = 21'h02029;
    localparam logic [CP_W-1:0] WS_NNBSP  = 21'h0202F;
    localparam logic [CP_W-1:0] WS_MMSP   = 21'h0205F;
    localparam logic [CP_W-1:0] WS_IDEO   = 21'h03000;

    typedef struct packed {
        logic                reorder;
        logic                invisible;
        logic                space;
        logic [SCRIPT_W-1:0] script;
    } cp_class_t;

    // true when two or more script bits are set
    function automatic logic several_scripts(input logic [SCRIPT_W-1:0] s);
        several_scripts = (s[0] & s[1]) | (s[0] & s[2]) | (s[1] & s[2]);
    endfunction

endpackage

[design/mstxi_classify.sv]
`timescale 1ns / 1ps

module mstxi_classify
(
    input  logic [mstxi_pkg::CP_W-1:0] code_point,
    output mstxi_pkg::cp_class_t       cls
);

    logic [mstxi_pkg::CP_W-1:0] c;

    assign c = code_point;

    always_comb
    begin
        cls.reorder   = (c >= mstxi_pkg::BIDI_EMB_LO && c <= mstxi_pkg::BIDI_EMB_HI) ||
                        (c >= mstxi_pkg::BIDI_ISO_LO && c <= mstxi_pkg::BIDI_ISO_HI);
        cls.invisible = (c >= mstxi_pkg::ZW_LO && c <= mstxi_pkg::ZW_HI) ||
                        (c == mstxi_pkg::ZW_WJ) || (c == mstxi_pkg::ZW_BOM);
        cls.space     = (c >= mstxi_pkg::WS_CTL_LO && c <= mstxi_pkg::WS_CTL_HI) ||
                        (c == mstxi_pkg::WS_SPACE) || (c == mstxi_pkg::WS_NEL) ||
                        (c == mstxi_pkg::WS_NBSP)  || (c == mstxi_pkg::WS_OGHAM) ||
                        (c >= mstxi_pkg::WS_EN_LO && c <= mstxi_pkg::WS_EN_HI) ||
                        (c == mstxi_pkg::WS_LSEP)  || (c == mstxi_pkg::WS_PSEP) ||
                        (c == mstxi_pkg::WS_NNBSP) || (c == mstxi_pkg::WS_MMSP) ||
                        (c == mstxi_pkg::WS_IDEO);
        // letter ranges are disjoint
        unique if ((c >= mstxi_pkg::LAT_UP_LO && c <= mstxi_pkg::LAT_UP_HI) ||
                   (c >= mstxi_pkg::LAT_LO_LO && c <= mstxi_pkg::LAT_LO_HI))
        begin
            cls.script = mstxi_pkg::SCRIPT_LATIN;
        end
        else if (c >= mstxi_pkg::CYR_LO && c <= mstxi_pkg::CYR_HI)
        begin
            cls.script = mstxi_pkg::SCRIPT_CYRILLIC;
        end
        else if (c >= mstxi_pkg::GRK_LO && c <= mstxi_pkg::GRK_HI)
        begin
            cls.script = mstxi_pkg::SCRIPT_GREEK;
        end
        else
        begin
            cls.script = mstxi_pkg::SCRIPT_NONE;
        end
    end

endmodule

[design/mstxi_track.sv]
`timescale 1ns / 1ps

module mstxi_track
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 end_of_name,
    input  mstxi_pkg::cp_class_t cls,
    output logic                 keep,
    output logic                 reorders_text,
    output logic                 hides_characters,
    output logic                 mixes_scripts,
    output logic                 idle_state
);

    logic [mstxi_pkg::SCRIPT_W-1:0] word_scripts_reg, word_scripts_next, word_upd;
    logic reorder_seen_reg, reorder_seen_next, reorder_upd;
    logic hidden_seen_reg, hidden_seen_next, hidden_upd;
    logic mixed_seen_reg, mixed_seen_next, mixed_upd, mixed_fin;

    always_comb
    begin
        word_upd    = word_scripts_reg;
        reorder_upd = reorder_seen_reg;
        hidden_upd  = hidden_seen_reg;
        mixed_upd   = mixed_seen_reg;
        keep        = 1'b1;
        priority if (cls.reorder)
        begin
            reorder_upd = 1'b1;
            keep        = 1'b0;
        end
        else if (cls.invisible)
        begin
            hidden_upd = 1'b1;
            keep       = 1'b0;
        end
        else if (cls.script != mstxi_pkg::SCRIPT_NONE)
        begin
            word_upd = word_scripts_reg | cls.script;
        end
        else if (cls.space)
        begin
            // whitespace closes the word
            mixed_upd = mixed_seen_reg | mstxi_pkg::several_scripts(word_scripts_reg);
            word_upd  = mstxi_pkg::SCRIPT_NONE;
        end
        else
        begin
            word_upd = word_scripts_reg;
        end

        // end of name closes any open word too
        mixed_fin = mixed_upd | mstxi_pkg::several_scripts(word_upd);

        reorders_text    = end_of_name & reorder_upd;
        hides_characters = end_of_name & hidden_upd;
        mixes_scripts    = end_of_name & mixed_fin;

        if (end_of_name)
        begin
            word_scripts_next = mstxi_pkg::SCRIPT_NONE;
            reorder_seen_next = 1'b0;
            hidden_seen_next  = 1'b0;
            mixed_seen_next   = 1'b0;
        end
        else
        begin
            word_scripts_next = word_upd;
            reorder_seen_next = reorder_upd;
            hidden_seen_next  = hidden_upd;
            mixed_seen_next   = mixed_upd;
        end
    end

    assign idle_state = (word_scripts_reg == mstxi_pkg::SCRIPT_NONE) &&
                        !reorder_seen_reg && !hidden_seen_reg && !mixed_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_scripts_reg <= mstxi_pkg::SCRIPT_NONE;
            reorder_seen_reg <= 1'b0;
            hidden_seen_reg  <= 1'b0;
            mixed_seen_reg   <= 1'b0;
        end
        else if (advance)
        begin
            word_scripts_reg <= word_scripts_next;
            reorder_seen_reg <= reorder_seen_next;
            hidden_seen_reg  <= hidden_seen_next;
            mixed_seen_reg   <= mixed_seen_next;
        end
    end

endmodule

[design/mixed_script_text_inspector_core.sv]
`timescale 1ns / 1ps
// Path: an accepted input goes to the input register, then the result register.
// Throughput: one code point per cycle while m_axis_tready allows, set by the
//   input register feeding the combinational classifier and flag update.
// Reset: rst_n (async, active low) empties both registers and clears the word
//   script set and the three sticky flags.

`include "mixed_script_text_inspector_core_defines.svh"

module mixed_script_text_inspector_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_axis_tlast,   // end_of_name

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] char_out, [21] reorders_text,
                                        // [22] hides_characters, [23] mixes_scripts
    output logic        m_axis_tuser,   // keep
    output logic        m_axis_tlast    // last
);

    // Input register stage
    logic                         in_valid_reg, in_valid_next;
    logic [mstxi_pkg::CP_W-1:0]   in_cp_reg;
    logic                         in_last_reg;

    // Result register stage
    logic                         out_valid_reg, out_valid_next;
    logic [mstxi_pkg::CP_W-1:0]   out_cp_reg;
    logic                         out_keep_reg;
    logic                         out_last_reg;
    logic [2:0]                   out_flags_reg;

    logic                 in_take;
    logic                 advance;
    mstxi_pkg::cp_class_t cls;
    logic                 keep;
    logic                 reorders_text;
    logic                 hides_characters;
    logic                 mixes_scripts;
    logic                 idle_state;

    // The input stage moves into the result stage whenever the result stage is
    // empty or being drained, so both sides run at full rate.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !advance);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    mstxi_classify u_classify
    (
        .code_point (in_cp_reg),
        .cls        (cls)
    );

    // Word script set and sticky flags; updated only as a transaction leaves
    // the input stage so stalls never double-count a code point.
    mstxi_track u_track
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .end_of_name      (in_last_reg),
        .cls              (cls),
        .keep             (keep),
        .reorders_text    (reorders_text),
        .hides_characters (hides_characters),
        .mixes_scripts    (mixes_scripts),
        .idle_state       (idle_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cp_reg   <= s_axis_tdata[mstxi_pkg::CP_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_cp_reg    <= in_cp_reg;
            out_keep_reg  <= keep;
            out_last_reg  <= in_last_reg;
            out_flags_reg <= {mixes_scripts, hides_characters, reorders_text};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_flags_reg, out_cp_reg};
    assign m_axis_tuser  = out_keep_reg;
    assign m_axis_tlast  = out_last_reg;

    // Flags are only reported on the last code point of a name.
    `MSTXI_ASSERT_IMP(a_flags_only_on_last, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[23:21] == 3'b000, "flags set on non-last result")
    // A dropped last character must itself be reported as reordering or hidden.
    `MSTXI_ASSERT_IMP(a_drop_flagged, m_axis_tvalid && m_axis_tlast && !m_axis_tuser, m_axis_tdata[21] || m_axis_tdata[22], "dropped last character not flagged")
    // Name state is cleared once the end item has passed through.
    `MSTXI_ASSERT_NEXT(a_clear_after_end, advance && in_last_reg, idle_state, "state not cleared after end of name")

endmodule

[test/tb_mixed_script_text_inspector_core.sv]
`timescale 1ns / 1ps

module tb_mixed_script_text_inspector_core;

    localparam int unsigned CP_W         = mstxi_pkg::CP_W;
    localparam int unsigned SCRIPT_W     = mstxi_pkg::SCRIPT_W;
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PRINT_CAP    = 200;

    // one echoed code point with its keep bit and the name flags
    typedef struct {
        logic [CP_W-1:0] ch;
        logic            keep;
        logic            last;
        logic            reorder;
        logic            hidden;
        logic            mixed;
    } glyph_result_t;

    // Tracks the name flags the core should report and queues the echo
    // expected for every accepted code point.
    class name_flag_scoreboard;
        glyph_result_t       awaited[$];
        logic [SCRIPT_W-1:0] word_scripts;
        logic                reorder_seen;
        logic                hidden_seen;
        logic                mixed_seen;

        function new();
            clear_name_state();
        endfunction

        function void clear_name_state();
            word_scripts = mstxi_pkg::SCRIPT_NONE;
            reorder_seen = 1'b0;
            hidden_seen  = 1'b0;
            mixed_seen   = 1'b0;
        endfunction

        function bit is_bidi_control(logic [CP_W-1:0] c);
            return (c >= mstxi_pkg::BIDI_EMB_LO && c <= mstxi_pkg::BIDI_EMB_HI) ||
                   (c >= mstxi_pkg::BIDI_ISO_LO && c <= mstxi_pkg::BIDI_ISO_HI);
        endfunction

        function bit is_zero_width(logic [CP_W-1:0] c);
            return (c >= mstxi_pkg::ZW_LO && c <= mstxi_pkg::ZW_HI) ||
                   c == mstxi_pkg::ZW_WJ || c == mstxi_pkg::ZW_BOM;
        endfunction

        function logic [SCRIPT_W-1:0] script_of(logic [CP_W-1:0] c);
            if ((c >= mstxi_pkg::LAT_UP_LO && c <= mstxi_pkg::LAT_UP_HI) ||
                (c >= mstxi_pkg::LAT_LO_LO && c <= mstxi_pkg::LAT_LO_HI))
                return mstxi_pkg::SCRIPT_LATIN;
            if (c >= mstxi_pkg::CYR_LO && c <= mstxi_pkg::CYR_HI)
                return mstxi_pkg::SCRIPT_CYRILLIC;
            if (c >= mstxi_pkg::GRK_LO && c <= mstxi_pkg::GRK_HI)
                return mstxi_pkg::SCRIPT_GREEK;
            return mstxi_pkg::SCRIPT_NONE;
        endfunction

        function bit is_word_break(logic [CP_W-1:0] c);
            return (c >= mstxi_pkg::WS_CTL_LO && c <= mstxi_pkg::WS_CTL_HI) ||
                   c == mstxi_pkg::WS_SPACE || c == mstxi_pkg::WS_NEL ||
                   c == mstxi_pkg::WS_NBSP || c == mstxi_pkg::WS_OGHAM ||
                   (c >= mstxi_pkg::WS_EN_LO && c <= mstxi_pkg::WS_EN_HI) ||
                   c == mstxi_pkg::WS_LSEP || c == mstxi_pkg::WS_PSEP ||
                   c == mstxi_pkg::WS_NNBSP || c == mstxi_pkg::WS_MMSP ||
                   c == mstxi_pkg::WS_IDEO;
        endfunction

        // a word with two or more script bits marks the name as mixed
        function void close_word();
            if ((word_scripts & (word_scripts - 1'b1)) != '0)
                mixed_seen = 1'b1;
            word_scripts = mstxi_pkg::SCRIPT_NONE;
        endfunction

        function void note_input(logic [CP_W-1:0] cp, logic eon);
            glyph_result_t       r;
            logic [SCRIPT_W-1:0] s;
            r.ch      = cp;
            r.keep    = 1'b1;
            r.last    = eon;
            r.reorder = 1'b0;
            r.hidden  = 1'b0;
            r.mixed   = 1'b0;
            if (is_bidi_control(cp))
            begin
                reorder_seen = 1'b1;
                r.keep       = 1'b0;
            end
            else if (is_zero_width(cp))
            begin
                hidden_seen = 1'b1;
                r.keep      = 1'b0;
            end
            else
            begin
                s = script_of(cp);
                if (s != mstxi_pkg::SCRIPT_NONE)
                    word_scripts = word_scripts | s;
                else if (is_word_break(cp))
                    close_word();
            end
            if (eon)
            begin
                // an open word still counts at the end of the name
                close_word();
                r.reorder = reorder_seen;
                r.hidden  = hidden_seen;
                r.mixed   = mixed_seen;
                clear_name_state();
            end
            awaited.push_back(r);
        endfunction

        function string check_result(glyph_result_t got);
            glyph_result_t want;
            string         msg;
            if (awaited.size() == 0)
                return $sformatf("result with nothing pending: char_out %h", got.ch);
            want = awaited.pop_front();
            msg  = "";
            if (got.ch !== want.ch)
                msg = {msg, $sformatf(" char_out %h/%h", got.ch, want.ch)};
            if (got.keep !== want.keep)
                msg = {msg, $sformatf(" keep %b/%b", got.keep, want.keep)};
            if (got.last !== want.last)
                msg = {msg, $sformatf(" last %b/%b", got.last, want.last)};
            if (got.reorder !== want.reorder)
                msg = {msg, $sformatf(" reorders_text %b/%b", got.reorder, want.reorder)};
            if (got.hidden !== want.hidden)
                msg = {msg, $sformatf(" hides_characters %b/%b", got.hidden, want.hidden)};
            if (got.mixed !== want.mixed)
                msg = {msg, $sformatf(" mixes_scripts %b/%b", got.mixed, want.mixed)};
            if (msg != "")
                msg = {$sformatf("char %h (got/want):", want.ch), msg};
            return msg;
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    name_flag_scoreboard sb = new();
    int unsigned         mismatches = 0;
    int unsigned         cycle_count = 0;
    int unsigned         items_sent = 0;
    bit                  quiet_phase = 1'b0;    // no gaps on either side while set

    mixed_script_text_inspector_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Present one code point; returns at the edge where it was taken.
    task automatic send_item(input logic [CP_W-1:0] cp, input logic eon);
        int unsigned gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cp};
        s_axis_tlast  <= eon;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(cp, eon);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CP_W-1:0] pick_space();
        case ($urandom_range(0, 15))
            0:       return CP_W'($urandom_range(mstxi_pkg::WS_CTL_LO, mstxi_pkg::WS_CTL_HI));
            1:       return mstxi_pkg::WS_NEL;
            2:       return mstxi_pkg::WS_NBSP;
            3:       return mstxi_pkg::WS_OGHAM;
            4:       return CP_W'($urandom_range(mstxi_pkg::WS_EN_LO, mstxi_pkg::WS_EN_HI));
            5:       return mstxi_pkg::WS_LSEP;
            6:       return mstxi_pkg::WS_PSEP;
            7:       return mstxi_pkg::WS_NNBSP;
            8:       return mstxi_pkg::WS_MMSP;
            9:       return mstxi_pkg::WS_IDEO;
            default: return mstxi_pkg::WS_SPACE;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] pick_letter(input int unsigned script);
        case (script)
            0:       return $urandom_range(0, 1)
                         ? CP_W'($urandom_range(mstxi_pkg::LAT_UP_LO, mstxi_pkg::LAT_UP_HI))
                         : CP_W'($urandom_range(mstxi_pkg::LAT_LO_LO, mstxi_pkg::LAT_LO_HI));
            1:       return CP_W'($urandom_range(mstxi_pkg::CYR_LO, mstxi_pkg::CYR_HI));
            default: return CP_W'($urandom_range(mstxi_pkg::GRK_LO, mstxi_pkg::GRK_HI));
        endcase
    endfunction

    // mostly classless code points, many sitting just outside a class boundary
    function automatic logic [CP_W-1:0] pick_neutral();
        case ($urandom_range(0, 9))
            0:       return 21'h00040;
            1:       return 21'h0005B;
            2:       return 21'h00060;
            3:       return 21'h0007B;
            4:       return 21'h0036F;
            5:       return 21'h00530;
            6:       return CP_W'($urandom_range(21'h0D800, 21'h0DFFF));   // surrogates
            7:       return CP_W'($urandom_range(21'h0202F - 21'h0000F, 21'h0206F));
            8:       return CP_W'($urandom_range(21'h00030, 21'h00039));
            default: return CP_W'($urandom_range(21'h04E00, 21'h09FFF));
        endcase
    endfunction

    function automatic logic [CP_W-1:0] pick_char(input int unsigned main_script,
                                                  input bit mixing);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return pick_letter((mixing && $urandom_range(0, 2) == 0) ?
                               $urandom_range(0, 2) : main_script);
        if (roll < 72)
            return pick_space();
        if (roll < 77)
            return $urandom_range(0, 1)
                ? CP_W'($urandom_range(mstxi_pkg::BIDI_EMB_LO, mstxi_pkg::BIDI_EMB_HI))
                : CP_W'($urandom_range(mstxi_pkg::BIDI_ISO_LO, mstxi_pkg::BIDI_ISO_HI));
        if (roll < 82)
        begin
            case ($urandom_range(0, 2))
                0:       return CP_W'($urandom_range(mstxi_pkg::ZW_LO, mstxi_pkg::ZW_HI));
                1:       return mstxi_pkg::ZW_WJ;
                default: return mstxi_pkg::ZW_BOM;
            endcase
        end
        if (roll < 92)
            return pick_neutral();
        return CP_W'($urandom_range(0, 21'h1FFFFF));
    endfunction

    // A name of words with random content; a few are pure noise.
    task automatic send_name();
        int unsigned     len;
        int unsigned     main_script;
        bit              mixing;
        bit              noise;
        logic [CP_W-1:0] cp;
        len         = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 30)
                                                  : $urandom_range(1, 10);
        main_script = $urandom_range(0, 2);
        mixing      = ($urandom_range(0, 3) == 0);
        noise       = ($urandom_range(0, 9) == 0);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (noise)
                cp = CP_W'($urandom_range(0, 21'h1FFFFF));
            else
                cp = pick_char(main_script, mixing);
            send_item(cp, i == len - 1);
        end
    endtask

    // Result side: random stalls, each accepted transaction checked in order.
    initial
    begin
        glyph_result_t got;
        string         msg;
        int unsigned   stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            got.ch      = m_axis_tdata[20:0];
            got.reorder = m_axis_tdata[21];
            got.hidden  = m_axis_tdata[22];
            got.mixed   = m_axis_tdata[23];
            got.keep    = m_axis_tuser;
            got.last    = m_axis_tlast;
            msg = sb.check_result(got);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bidi + Latin/Cyrillic word, zero width, Greek end item
        send_item(21'h0202A, 1'b0);
        send_item(21'h00041, 1'b0);
        send_item(21'h00400, 1'b0);
        send_item(mstxi_pkg::WS_SPACE, 1'b0);
        send_item(21'h0007A, 1'b0);
        send_item(21'h0200B, 1'b0);
        send_item(21'h00370, 1'b1);
        // whitespace as the end item, single-script word
        send_item(21'h0005A, 1'b0);
        send_item(21'h0202E, 1'b0);
        send_item(21'h00061, 1'b0);
        send_item(21'h00009, 1'b1);
        // bidi control inside a word does not split it; open word closed at end
        send_item(21'h0052F, 1'b0);
        send_item(21'h02066, 1'b0);
        send_item(21'h003FF, 1'b1);
        // a bidi isolate and zero-width characters inside a word, ideographic space ends the name
        send_item(21'h00041, 1'b0);
        send_item(21'h02069, 1'b0);
        send_item(21'h0200D, 1'b0);
        send_item(21'h02060, 1'b0);
        send_item(21'h0FEFF, 1'b0);
        send_item(21'h00400, 1'b0);
        send_item(mstxi_pkg::WS_IDEO, 1'b1);
        // out of range, top scalar, surrogate, zero: no class at all
        send_item(21'h1FFFFF, 1'b0);
        send_item(21'h10FFFF, 1'b0);
        send_item(21'h0D800,  1'b0);
        send_item(21'h00000,  1'b1);

        // hold the input until the core has handed everything back
        s_axis_tvalid <= 1'b0;
        wait_for_drain();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                quiet_phase = !quiet_phase;
            if ($urandom_range(0, 39) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                wait_for_drain();
            end
            send_name();
        end
        s_axis_tvalid <= 1'b0;
        quiet_phase = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/mstxi_pkg.sv
design/mstxi_classify.sv
design/mstxi_track.sv
design/mixed_script_text_inspector_core.sv
test/tb_mixed_script_text_inspector_core.sv
